>>> hw/rtl/postfix_stack_evaluator_macros.svh
// Assertion macros shared by the postfix stack evaluator RTL.
`ifndef POSTFIX_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSEV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("psev: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSEV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("psev: next-cycle check failed");

`endif

>>> hw/rtl/psev_pkg.sv
// Types and constants of the postfix stack evaluator.
package psev_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 16;
	localparam int unsigned DATA_W          = 32;
	localparam int unsigned CMD_W           = 3;
	localparam int unsigned DEPTH_OUT_W     = 5;
	localparam int unsigned STATUS_W        = 2;

	// Token kinds.
	localparam logic [CMD_W-1:0] CMD_NUMBER = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SUB    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_MUL    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DIV    = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_DIVZERO   = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] number_value;
		logic                     end_of_expression;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  top_value;
		logic [DEPTH_OUT_W-1:0]    stack_depth;
		logic [STATUS_W-1:0]       status;
		logic                      expression_done;
	} out_t;

	// Shift control of one stack cell.
	typedef struct packed {
		logic shift_down;
		logic shift_up;
	} cell_ctrl_t;

endpackage

>>> hw/rtl/psev_cell.sv
// One stack cell: holds a value and shifts it toward either neighbor.
module psev_cell (
	input  logic                            clk,
	input  psev_pkg::cell_ctrl_t            ctrl,
	input  logic [psev_pkg::DATA_W-1:0]     from_above,
	input  logic [psev_pkg::DATA_W-1:0]     from_below,
	output logic [psev_pkg::DATA_W-1:0]     value
);
	import psev_pkg::*;

	logic [DATA_W-1:0] value_q;

	// A push moves values down the chain, a pop moves them back up.
	always_ff @(posedge clk) begin
		if (ctrl.shift_down) begin
			value_q <= from_above;
		end else if (ctrl.shift_up) begin
			value_q <= from_below;
		end
	end

	assign value = value_q;

endmodule

>>> hw/rtl/psev_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module psev_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [psev_pkg::DATA_W-1:0] dividend,
	input  logic [psev_pkg::DATA_W-1:0] divisor,
	output logic                        done,
	output logic [psev_pkg::DATA_W-1:0] quotient
);
	import psev_pkg::*;

	localparam int unsigned CNT_W = $clog2(DATA_W + 1);

	logic              busy_q;
	logic              fix_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic [DATA_W-1:0] dvd_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W+1:0] diff;
	logic              qbit;

	// Trial subtraction of the divisor from the shifted partial remainder.
	assign shifted = {rem_q, dvd_q[DATA_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign qbit    = ~diff[DATA_W+1];

	// Step counter and the one-cycle done flag at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			fix_q  <= 1'b0;
			cnt_q  <= CNT_W'(DATA_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				fix_q  <= 1'b1;
			end
		end else begin
			fix_q <= 1'b0;
		end
	end

	// Operand magnitudes in, then quotient bits shift into the dividend register.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			dvd_q <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
			dvs_q <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
			dvd_q <= {dvd_q[DATA_W-2:0], qbit};
		end
	end

	assign done     = fix_q;
	assign quotient = neg_q ? (DATA_W'(0) - dvd_q) : dvd_q;

endmodule

>>> hw/rtl/postfix_stack_evaluator.sv
// Top level of the postfix stack evaluator: control, ALU and the cell chain.
// Postfix (reverse Polish) integer evaluator, one token per input transaction.
// Input channel: in_valid / in_stall with in_item (cmd, number_value,
// end_of_expression). Output channel: out_valid / out_stall with out_item
// (top_value, stack_depth, status, expression_done), one result per token.
// The value stack is a chain of STACK_DEPTH cells; cell 0 is the top of stack.
// A push shifts the chain down, an operator replaces cell 0 with its result
// and shifts the rest up, so each push or pop moves the whole chain at once.
// Sequence: a token is captured in FSM_IDLE and executed in FSM_ALU; a number,
// add, subtract or multiply token (and any faulting token) goes on to FSM_EMIT,
// a divide first waits in FSM_DIV for the 32-step bit-serial divider and then
// writes its quotient back; FSM_EMIT loads the result into the output register.
// Only one token is in flight; in_stall is high until its result has been
// loaded into the output register, which then waits there while out_stall
// is high, while the next token may already be accepted.
// Reset (arst_n low) empties the stack and drops any pending result.
// An end_of_expression token empties the stack after its result is produced.
module postfix_stack_evaluator #(
	parameter int unsigned STACK_DEPTH = psev_pkg::STACK_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  psev_pkg::in_t  in_item,
	output logic           out_valid,
	input  logic           out_stall,
	output psev_pkg::out_t out_item
);
	import psev_pkg::*;
	`include "postfix_stack_evaluator_macros.svh"

	localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);

	typedef enum logic [3:0] {
		FSM_IDLE = 4'b0001,
		FSM_ALU  = 4'b0010,
		FSM_DIV  = 4'b0100,
		FSM_EMIT = 4'b1000
	} fsm_t;

	fsm_t                state_q, state_d;
	logic [CMD_W-1:0]    cmd_q;
	logic [DATA_W-1:0]   num_q;
	logic                eoe_q;
	logic [STATUS_W-1:0] status_q, status_d;
	logic [SP_W-1:0]     sp_q, sp_d;
	logic                out_valid_q;
	out_t                out_item_q;

	logic [DATA_W-1:0]   cell_val [STACK_DEPTH];
	cell_ctrl_t          cell_ctrl [STACK_DEPTH];
	logic [DATA_W-1:0]   load_val;
	logic [DATA_W-1:0]   right_w;
	logic [DATA_W-1:0]   left_w;
	logic [DATA_W-1:0]   prod_w;
	logic                push;
	logic                pop;
	logic                out_free;
	logic                emit;
	logic                div_start;
	logic                div_done;
	logic [DATA_W-1:0]   div_quo;

	assign right_w  = cell_val[0];
	assign left_w   = cell_val[1];
	assign prod_w   = left_w * right_w;
	assign out_free = !out_valid_q || !out_stall;
	assign emit     = (state_q == FSM_EMIT) && out_free;
	assign in_stall = (state_q != FSM_IDLE);

	// Token decode and stack control.
	always_comb begin
		state_d   = state_q;
		status_d  = status_q;
		sp_d      = sp_q;
		push      = 1'b0;
		pop       = 1'b0;
		div_start = 1'b0;
		load_val  = num_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (in_valid) begin
					state_d = FSM_ALU;
				end
			end
			FSM_ALU: begin
				status_d = STAT_OK;
				state_d  = FSM_EMIT;
				unique case (cmd_q) inside
					CMD_NUMBER: begin
						if (sp_q >= SP_W'(STACK_DEPTH)) begin
							status_d = STAT_FULL;
						end else begin
							push = 1'b1;
							sp_d = sp_q + SP_W'(1);
						end
					end
					CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
						if (sp_q < SP_W'(2)) begin
							status_d = STAT_UNDERFLOW;
						end else if (cmd_q == CMD_DIV) begin
							if (right_w == '0) begin
								status_d = STAT_DIVZERO;
							end else begin
								div_start = 1'b1;
								state_d   = FSM_DIV;
							end
						end else begin
							pop  = 1'b1;
							sp_d = sp_q - SP_W'(1);
							unique case (cmd_q)
								CMD_ADD: load_val = left_w + right_w;
								CMD_SUB: load_val = left_w - right_w;
								default: load_val = prod_w;
							endcase
						end
					end
					default: ;
				endcase
			end
			FSM_DIV: begin
				if (div_done) begin
					pop      = 1'b1;
					load_val = div_quo;
					sp_d     = sp_q - SP_W'(1);
					state_d  = FSM_EMIT;
				end
			end
			FSM_EMIT: begin
				if (out_free) begin
					state_d = FSM_IDLE;
					if (eoe_q) begin
						sp_d = '0;
					end
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			sp_q        <= '0;
			status_q    <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			sp_q     <= sp_d;
			status_q <= status_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Captured token and the output register.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_q <= in_item.cmd;
			num_q <= in_item.number_value;
			eoe_q <= in_item.end_of_expression;
		end
		if (emit) begin
			out_item_q.top_value       <= (sp_q != '0) ? cell_val[0] : '0;
			out_item_q.stack_depth     <= DEPTH_OUT_W'(sp_q);
			out_item_q.status          <= status_q;
			out_item_q.expression_done <= eoe_q;
		end
	end

	// Chain of stack cells; cell 0 takes the new value on both push and pop.
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] above;
		logic [DATA_W-1:0] below;

		if (i == 0) begin : g_top
			assign above               = load_val;
			assign cell_ctrl[i].shift_down = push || pop;
			assign cell_ctrl[i].shift_up   = 1'b0;
		end else begin : g_rest
			assign above               = cell_val[i-1];
			assign cell_ctrl[i].shift_down = push;
			assign cell_ctrl[i].shift_up   = pop;
		end

		if (i == STACK_DEPTH - 1) begin : g_last
			assign below = '0;
		end else begin : g_mid
			assign below = cell_val[i+1];
		end

		psev_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl[i]),
			.from_above (above),
			.from_below (below),
			.value      (cell_val[i])
		);
	end

	psev_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (left_w),
		.divisor  (right_w),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Checks on the control logic.
	`PSEV_ASSERT_IMPL(a_sp_bound, clk, arst_n, 1'b1, sp_q <= SP_W'(STACK_DEPTH))
	`PSEV_ASSERT_NEXT(a_accept_to_alu, clk, arst_n, in_valid && !in_stall, state_q == FSM_ALU)
	`PSEV_ASSERT_NEXT(a_emit_loads, clk, arst_n, emit, out_valid_q && state_q == FSM_IDLE)
	`PSEV_ASSERT_NEXT(a_eoe_clears, clk, arst_n, emit && eoe_q, sp_q == '0)
	`PSEV_ASSERT_IMPL(a_div_done_in_div, clk, arst_n, div_done, state_q == FSM_DIV)

endmodule

>>> bench/tb_postfix_stack_evaluator.sv
// Self-checking testbench for the postfix stack evaluator with a built-in token predictor.
`timescale 1ns / 1ps

module tb_postfix_stack_evaluator;
	import psev_pkg::*;

	localparam int unsigned STACK_DEPTH = STACK_DEPTH_DEF;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned DRAIN_EVERY = 400;
	localparam int unsigned RANDOM_TOKENS = 1700;
	localparam int unsigned SETTLE_CYCLES = 40;
	// Highest token kind the 3-bit field can carry; kinds above CMD_DIV are ignored.
	localparam logic [CMD_W-1:0] CMD_UNUSED_LAST = 3'd7;

	typedef struct {
		in_t tok;
		bit  drain_first;
	} pending_token_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_item;

	pending_token_t token_queue[$];
	out_t expected_reports[$];
	logic [DATA_W-1:0] model_stack[STACK_DEPTH];
	int unsigned model_level = 0;
	int unsigned total_tokens = 0;
	int unsigned tokens_presented = 0;
	int unsigned tokens_accepted = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	postfix_stack_evaluator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	always #5 clk = ~clk;

	// Applies one token to the model stack and returns the report it should produce.
	function automatic out_t evaluate_token(in_t tok);
		out_t rep;
		logic [DATA_W-1:0] lhs;
		logic [DATA_W-1:0] rhs;
		logic [DATA_W-1:0] res;
		logic [DATA_W-1:0] mag_l;
		logic [DATA_W-1:0] mag_r;
		logic [DATA_W-1:0] quo;
		bit ok;
		rep = '0;
		rep.status = STAT_OK;
		rep.expression_done = tok.end_of_expression;
		if (tok.cmd == CMD_NUMBER) begin
			if (model_level >= STACK_DEPTH) begin
				rep.status = STAT_FULL;
			end else begin
				model_stack[model_level] = tok.number_value;
				model_level++;
			end
		end else if (tok.cmd <= CMD_DIV) begin
			if (model_level < 2) begin
				rep.status = STAT_UNDERFLOW;
			end else begin
				rhs = model_stack[model_level-1];
				lhs = model_stack[model_level-2];
				res = '0;
				ok = 1'b1;
				case (tok.cmd)
					CMD_ADD: res = lhs + rhs;
					CMD_SUB: res = lhs - rhs;
					CMD_MUL: res = lhs * rhs;
					default: begin
						if (rhs == '0) begin
							ok = 1'b0;
							rep.status = STAT_DIVZERO;
						end else begin
							// Divide magnitudes, then restore the sign; truncates toward zero.
							mag_l = lhs[DATA_W-1] ? -lhs : lhs;
							mag_r = rhs[DATA_W-1] ? -rhs : rhs;
							quo = mag_l / mag_r;
							res = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -quo : quo;
						end
					end
				endcase
				if (ok) begin
					model_stack[model_level-2] = res;
					model_level--;
				end
			end
		end
		if (model_level > 0)
			rep.top_value = model_stack[model_level-1];
		rep.stack_depth = model_level[DEPTH_OUT_W-1:0];
		if (tok.end_of_expression)
			model_level = 0;
		return rep;
	endfunction

	// Operand values biased toward zero, small magnitudes and the extremes.
	function automatic logic [DATA_W-1:0] random_operand();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4, 5, 6: return $urandom_range(0, 40) - 20;
			default: return $urandom();
		endcase
	endfunction

	// Queues one token; every so often the sender must drain the block before it.
	function automatic void push_token(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value,
			logic eoe);
		pending_token_t p;
		p.tok.cmd = cmd;
		p.tok.number_value = value;
		p.tok.end_of_expression = eoe;
		p.drain_first = (token_queue.size() % DRAIN_EVERY == 0) && (token_queue.size() > 0);
		token_queue.push_back(p);
	endfunction

	// Well-formed expression with random content; sometimes deep enough to overfill.
	function automatic void add_expression();
		int depth;
		int cap;
		int len;
		int push_pct;
		int k;
		bit fill;
		fill = ($urandom_range(0, 9) == 0);
		cap = fill ? STACK_DEPTH + 1 : $urandom_range(2, 6);
		len = fill ? $urandom_range(16, 22) : $urandom_range(1, 12);
		push_pct = fill ? 85 : 50;
		depth = 0;
		for (k = 0; k < len; k++) begin
			if (depth < 2 || (depth < cap && $urandom_range(0, 99) < push_pct)) begin
				push_token(CMD_NUMBER, random_operand(), 1'b0);
				depth++;
			end else begin
				push_token(CMD_W'($urandom_range(CMD_ADD, CMD_DIV)), $urandom(), 1'b0);
				depth--;
			end
		end
		while (depth > 1) begin
			push_token(CMD_W'($urandom_range(CMD_ADD, CMD_DIV)), $urandom(), 1'b0);
			depth--;
		end
		token_queue[token_queue.size()-1].tok.end_of_expression = 1'b1;
	endfunction

	// Noise: any token kind, random payload, a stray end marker now and then.
	function automatic void add_noise();
		int n;
		int k;
		n = $urandom_range(1, 4);
		for (k = 0; k < n; k++)
			push_token(CMD_W'($urandom_range(CMD_NUMBER, CMD_UNUSED_LAST)), $urandom(),
				$urandom_range(0, 7) == 0);
	endfunction

	// Compares one report field and logs a mismatch.
	function automatic void check_field(string name, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Stimulus, reset and the end of the run.
	initial begin : run_control
		int k;
		// Underflow first, then a wrapping add, most negative over minus one, divide by zero on the last token.
		push_token(CMD_ADD, 32'h0, 1'b0);
		push_token(CMD_NUMBER, 32'h7FFF_FFFF, 1'b0);
		push_token(CMD_NUMBER, 32'h1, 1'b0);
		push_token(CMD_ADD, 32'hFFFF_FFFF, 1'b0);
		push_token(CMD_NUMBER, 32'hFFFF_FFFF, 1'b0);
		push_token(CMD_DIV, 32'h0, 1'b0);
		push_token(CMD_NUMBER, 32'h0, 1'b0);
		push_token(CMD_DIV, 32'h5555_5555, 1'b1);
		// Fill the stack, overflow it, then reduce once and end on an unused kind.
		for (k = 0; k < STACK_DEPTH; k++)
			push_token(CMD_NUMBER, random_operand(), 1'b0);
		push_token(CMD_NUMBER, 32'h8000_0000, 1'b0);
		push_token(CMD_MUL, 32'hAAAA_AAAA, 1'b0);
		push_token(CMD_UNUSED_LAST, 32'hFFFF_FFFF, 1'b1);
		k = token_queue.size();
		while (token_queue.size() < k + RANDOM_TOKENS) begin
			if ($urandom_range(0, 99) < 80)
				add_expression();
			else
				add_noise();
		end
		total_tokens = token_queue.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (tokens_accepted != total_tokens || expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Driver: presents tokens and sets the stall of the result channel at the falling edge.
	always @(negedge clk) begin
		int unsigned phase;
		int unsigned send_idle_pct;
		int unsigned recv_stall_pct;
		bit taken;
		phase = (total_tokens == 0) ? 0 : (tokens_accepted * 3) / total_tokens;
		case (phase)
			0: begin
				send_idle_pct = 26;
				recv_stall_pct = 76;
			end
			1: begin
				send_idle_pct = 76;
				recv_stall_pct = 26;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
		if (arst_n) begin
			taken = in_valid && (tokens_accepted == tokens_presented);
			if (!in_valid || taken) begin
				if (token_queue.size() > 0
						&& !(token_queue[0].drain_first && expected_reports.size() != 0)
						&& $urandom_range(0, 99) >= send_idle_pct) begin
					in_item <= token_queue[0].tok;
					in_valid <= 1'b1;
					void'(token_queue.pop_front());
					tokens_presented++;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Monitor: checks each report transaction, then predicts for each accepted token.
	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected report, expected none, actual %p", $time, out_item);
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					check_field("top_value", want.top_value, out_item.top_value);
					check_field("stack_depth", DATA_W'(want.stack_depth),
						DATA_W'(out_item.stack_depth));
					check_field("status", DATA_W'(want.status), DATA_W'(out_item.status));
					check_field("expression_done", DATA_W'(want.expression_done),
						DATA_W'(out_item.expression_done));
				end
			end
			if (in_valid && !in_stall) begin
				expected_reports.push_back(evaluate_token(in_item));
				tokens_accepted++;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

endmodule
